// ===== rtl/dre_pkg.sv =====
`default_nettype none
package dre_pkg;

  localparam int TIME_W  = 30;
  localparam int PCT_W   = 7;
  localparam int CFG_W   = 24;
  localparam int RATE_W  = 31;
  localparam int EMPTY_W = 37;

  // dividend width of the divide lane and of the four-fifths term
  localparam int DIV_W     = 33;
  localparam int DIV_STEPS = DIV_W;
  localparam int CNT_W     = 6;

  // divisor width: 5 * percent drop
  localparam int DEN_A_W = 10;

  // reciprocal of five, exact for dividends below 2^31
  localparam int                  RECIP_W    = 2 * RATE_W;
  localparam int                  RECIP_SH   = 33;
  localparam logic [RATE_W-1:0]   RECIP_FIVE = 31'd1717986919;

  // product pct * rate and the empty-time difference
  localparam int PROD_W = 39;

  localparam logic signed [CFG_W-1:0] DEFAULT_RATE_RST = -24'sd6048;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_SUM,
    ST_MUL,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic capture;
    logic classify;
    logic div_step;
    logic rate_upd;
    logic mul;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic dup;
    logic qualify;
    logic out_busy;
  } status_t;

endpackage
`default_nettype wire

// ===== rtl/dre_div.sv =====
`default_nettype none
module dre_div #(
  parameter int DW = 33,
  parameter int VW = 10
) (
  input  wire logic          clk,
  input  wire logic          load,
  input  wire logic          step,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [VW-1:0] divisor,
  output logic      [DW-1:0] quotient
);

  logic [DW-1:0] quo_r, quo_nxt;
  logic [VW-1:0] rem_r, rem_nxt;
  logic [VW-1:0] den_r;
  logic [VW:0]   trial;
  logic [VW:0]   diff;

  // one restoring step per cycle while step is high
  always_comb begin
    trial   = {rem_r, quo_r[DW-1]};
    diff    = trial - {1'b0, den_r};
    quo_nxt = {quo_r[DW-2:0], 1'b0};
    rem_nxt = trial[VW-1:0];
    if (trial >= {1'b0, den_r}) begin
      rem_nxt    = diff[VW-1:0];
      quo_nxt[0] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      quo_r <= dividend;
      rem_r <= '0;
      den_r <= divisor;
    end else if (step) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign quotient = quo_r;

endmodule
`default_nettype wire

// ===== rtl/dre_datapath.sv =====
`default_nettype none
module dre_datapath
  import dre_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire cmd_t                      cmd,
  output status_t                        sts,
  input  wire logic [TIME_W-1:0]         in_sample_time,
  input  wire logic [PCT_W-1:0]          in_charge_percent,
  input  wire logic                      in_is_charging,
  input  wire logic                      in_is_plugged,
  input  wire logic                      cfg_valid,
  input  wire logic signed [CFG_W-1:0]   cfg_default_rate,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic signed [RATE_W-1:0]       out_rate_out,
  output logic                           out_was_contiguous,
  output logic                           out_rate_changed,
  output logic [EMPTY_W-1:0]             out_empty_time
);

  logic [TIME_W-1:0]          t_r;
  logic [PCT_W-1:0]           pct_r;
  logic                       chg_r, plg_r;

  logic                       have_last_r;
  logic [TIME_W-1:0]          last_time_r;
  logic [PCT_W-1:0]           last_pct_r;
  logic                       last_chg_r, last_plg_r;
  logic signed [RATE_W-1:0]   running_rate_r;
  logic signed [CFG_W-1:0]    default_rate_r;

  logic signed [RATE_W-1:0]   work_rate_r;
  logic                       contig_r, changed_r;
  logic signed [PROD_W-1:0]   prod_r;
  logic                       out_valid_r;
  logic [RECIP_W-1:0]         recip_r;
  logic [DIV_W-1:0]           quo_b_r;

  logic [TIME_W-1:0]          dt;
  logic [PCT_W-1:0]           dp;
  logic [DEN_A_W-1:0]         den_a;
  logic [RATE_W-1:0]          rate_mag;
  logic [RATE_W-3:0]          fifth;
  logic [2:0]                 fifth_rem;
  logic [DIV_W-1:0]           four_fifths;
  logic [DIV_W-1:0]           quo_a;
  logic signed [DIV_W:0]      s4, s5, rate_sum;
  logic signed [PROD_W-1:0]   empty_diff;

  assign dt       = t_r - last_time_r;
  assign dp       = last_pct_r - pct_r;
  assign den_a    = {1'b0, dp, 2'b00} + {3'b000, dp};
  assign rate_mag = running_rate_r[RATE_W-1] ? (-running_rate_r) : running_rate_r;

  // floor(4m/5) = 4 * (m/5) + rem - (rem != 0)
  assign fifth       = recip_r[RECIP_W-1:RECIP_SH];
  assign fifth_rem   = rate_mag[2:0] - {fifth[0], 2'b00} - fifth[2:0];
  assign four_fifths = {2'b00, fifth, 2'b00} + {{(DIV_W-3){1'b0}}, fifth_rem} -
                       {{(DIV_W-1){1'b0}}, |fifth_rem};

  always_comb begin
    sts.dup      = have_last_r && (pct_r == last_pct_r) && (chg_r == last_chg_r) &&
                   (plg_r == last_plg_r);
    sts.qualify  = have_last_r && (t_r > last_time_r) && (pct_r < last_pct_r) &&
                   !chg_r && !last_chg_r;
    sts.out_busy = out_valid_r && !out_ready;
  end

  // quotient of dt by 5 * drop equals (dt / drop) / 5
  dre_div #(.DW(DIV_W), .VW(DEN_A_W)) u_div_a (
    .clk      (clk),
    .load     (cmd.classify),
    .step     (cmd.div_step),
    .dividend ({{(DIV_W-TIME_W){1'b0}}, dt}),
    .divisor  (den_a),
    .quotient (quo_a)
  );

  always_comb begin
    s4       = work_rate_r[RATE_W-1] ? -$signed({1'b0, quo_b_r}) : $signed({1'b0, quo_b_r});
    s5       = -$signed({1'b0, quo_a});
    rate_sum = s4 + s5;
    empty_diff = $signed({{(PROD_W-TIME_W){1'b0}}, t_r}) - prod_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      t_r   <= in_sample_time;
      pct_r <= in_charge_percent;
      chg_r <= in_is_charging;
      plg_r <= in_is_plugged;
    end
    if (cmd.classify) begin
      work_rate_r <= have_last_r ? running_rate_r : RATE_W'(default_rate_r);
      contig_r    <= have_last_r;
      changed_r   <= sts.qualify;
      recip_r     <= RECIP_W'(rate_mag) * RECIP_W'(RECIP_FIVE);
    end else if (cmd.rate_upd) begin
      work_rate_r <= rate_sum[RATE_W-1:0];
    end
    if (cmd.div_step) begin
      quo_b_r <= four_fifths;
    end
    if (cmd.mul) begin
      prod_r <= PROD_W'($signed({1'b0, pct_r})) * PROD_W'(work_rate_r);
    end
    if (cmd.emit) begin
      last_time_r        <= t_r;
      last_pct_r         <= pct_r;
      last_chg_r         <= chg_r;
      last_plg_r         <= plg_r;
      running_rate_r     <= work_rate_r;
      out_rate_out       <= work_rate_r;
      out_was_contiguous <= contig_r;
      out_rate_changed   <= changed_r;
      out_empty_time     <= empty_diff[PROD_W-1] ? '0 : empty_diff[EMPTY_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_last_r    <= 1'b0;
      default_rate_r <= DEFAULT_RATE_RST;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_valid) begin
        default_rate_r <= cfg_default_rate;
      end
      if (cmd.emit) begin
        have_last_r <= 1'b1;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;

  a_changed_contig: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_rate_changed |-> out_was_contiguous)
    else $error("rate update reported without contiguity");

  a_contig_have_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !have_last_r |-> 1'b0)
    else $error("result present with no stored sample");

endmodule
`default_nettype wire

// ===== rtl/dre_ctrl.sv =====
`default_nettype none
module dre_ctrl
  import dre_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire status_t sts,
  output cmd_t         cmd
);

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd.classify = 1'b1;
        cnt_nxt      = '0;
        if (sts.dup) begin
          state_nxt = ST_IDLE;
        end else if (sts.qualify) begin
          state_nxt = ST_DIV;
        end else begin
          state_nxt = ST_MUL;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = ST_SUM;
        end
      end
      ST_SUM: begin
        cmd.rate_upd = 1'b1;
        state_nxt    = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!sts.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> cnt_r < CNT_W'(DIV_STEPS))
    else $error("divide step count overrun");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !sts.out_busy)
    else $error("result loaded over an untaken result");

  a_accept_check: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == ST_CHECK)
    else $error("accepted item not classified");

endmodule
`default_nettype wire

// ===== rtl/discharge_rate_estimator_core.sv =====
// flow: an accepted sample is classified and a duplicate is dropped there;
// a sample with a rate update runs the 33 steps of the serial divide lane
// and the rate sum; every kept sample then takes the product and waits in emit
// while a result is untaken. A new sample is accepted only back in idle.
// reset (rst_n low, synchronous): no stored sample, default rate -6048, no result
`default_nettype none
module discharge_rate_estimator_core
  import dre_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [TIME_W-1:0]       in_sample_time,
  input  wire logic [PCT_W-1:0]        in_charge_percent,
  input  wire logic                    in_is_charging,
  input  wire logic                    in_is_plugged,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic signed [RATE_W-1:0]     out_rate_out,
  output logic                         out_was_contiguous,
  output logic                         out_rate_changed,
  output logic [EMPTY_W-1:0]           out_empty_time,
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic signed [CFG_W-1:0] cfg_default_rate
);

  cmd_t    cmd;
  status_t sts;

  assign cfg_ready = 1'b1;

  dre_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dre_datapath u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_sample_time     (in_sample_time),
    .in_charge_percent  (in_charge_percent),
    .in_is_charging     (in_is_charging),
    .in_is_plugged      (in_is_plugged),
    .cfg_valid          (cfg_valid),
    .cfg_default_rate   (cfg_default_rate),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_rate_out       (out_rate_out),
    .out_was_contiguous (out_was_contiguous),
    .out_rate_changed   (out_rate_changed),
    .out_empty_time     (out_empty_time)
  );

endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
module testbench;
  import dre_pkg::*;

  localparam int DRAIN_CYCLES = 60;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    logic signed [RATE_W-1:0] rate;
    logic                     contiguous;
    logic                     changed;
    logic [EMPTY_W-1:0]       empty_time;
  } discharge_estimate_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [TIME_W-1:0] in_sample_time = '0;
  logic [PCT_W-1:0] in_charge_percent = '0;
  logic in_is_charging = 1'b0;
  logic in_is_plugged = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [RATE_W-1:0] out_rate_out;
  logic out_was_contiguous;
  logic out_rate_changed;
  logic [EMPTY_W-1:0] out_empty_time;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic signed [CFG_W-1:0] cfg_default_rate = '0;

  discharge_rate_estimator_core i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_sample_time     (in_sample_time),
    .in_charge_percent  (in_charge_percent),
    .in_is_charging     (in_is_charging),
    .in_is_plugged      (in_is_plugged),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_rate_out       (out_rate_out),
    .out_was_contiguous (out_was_contiguous),
    .out_rate_changed   (out_rate_changed),
    .out_empty_time     (out_empty_time),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_default_rate   (cfg_default_rate)
  );

  // estimator state as seen by the bench
  longint est_default_rate = -6048;
  bit     est_have_last = 1'b0;
  longint est_last_time = 0;
  longint est_last_pct = 0;
  bit     est_last_chg = 1'b0;
  bit     est_last_plg = 1'b0;
  bit     est_last_contig = 1'b0;
  longint est_rate = 0;
  bit     est_active = 1'b0;

  discharge_estimate_t estimates_due[$];
  int mismatches = 0;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int hold_trigger = 0;
  int hold_seen = 0;
  int hold_left = 0;

  logic [TIME_W-1:0] gen_time = '0;
  int gen_pct = 100;
  logic gen_chg = 1'b0;
  logic gen_plg = 1'b0;

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic bit estimate_discharge(input logic [TIME_W-1:0] t_in,
                                            input logic [PCT_W-1:0] p_in,
                                            input logic chg, input logic plg,
                                            output discharge_estimate_t est);
    longint t, pct, rate, q, predicted, empty;
    bit own, contig, changed;
    t = longint'(t_in);
    pct = longint'(p_in);
    own = est_active;
    contig = 1'b0;
    changed = 1'b0;
    if (est_have_last && pct == est_last_pct && chg == est_last_chg && plg == est_last_plg)
      return 1'b0;
    if (!est_have_last) begin
      rate = est_default_rate;
    end else begin
      rate = est_rate;
      if (own) begin
        contig = 1'b1;
      end else if (!est_last_contig || pct > est_last_pct) begin
        contig = 1'b0;
      end else begin
        predicted = est_last_time - 10 * rate;
        contig = (t < predicted) || (t - predicted < (t - est_last_time) / 2);
      end
      if (t > est_last_time && pct < est_last_pct && !chg && !est_last_chg && contig) begin
        q = (t - est_last_time) / (pct - est_last_pct);
        rate = (rate * 4) / 5 + q / 5;
        changed = 1'b1;
      end
    end
    est_have_last = 1'b1;
    est_last_time = t;
    est_last_pct = pct;
    est_last_chg = chg;
    est_last_plg = plg;
    est_last_contig = own;
    est_rate = rate;
    est_active = 1'b1;
    empty = t + pct * (-rate);
    if (empty < 0)
      empty = 0;
    est.rate = rate[RATE_W-1:0];
    est.contiguous = contig;
    est.changed = changed;
    est.empty_time = empty[EMPTY_W-1:0];
    return 1'b1;
  endfunction

  task automatic check_estimate();
    discharge_estimate_t want;
    if (estimates_due.size() == 0) begin
      if (mismatches < 10)
        $display("unexpected item: rate %0d contig %0b changed %0b empty %0d",
                 out_rate_out, out_was_contiguous, out_rate_changed, out_empty_time);
      mismatches++;
    end else begin
      want = estimates_due.pop_front();
      if (want.rate !== out_rate_out || want.contiguous !== out_was_contiguous ||
          want.changed !== out_rate_changed || want.empty_time !== out_empty_time) begin
        if (mismatches < 10)
          $display("mismatch: rate %0d/%0d contig %0b/%0b changed %0b/%0b empty %0d/%0d",
                   want.rate, out_rate_out, want.contiguous, out_was_contiguous,
                   want.changed, out_rate_changed, want.empty_time, out_empty_time);
        mismatches++;
      end
    end
  endtask

  // result side: random stalls plus an occasional long hold
  always @(posedge clk) begin
    if (hold_trigger != hold_seen) begin
      hold_seen <= hold_trigger;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
    if (rst_n && out_valid && out_ready)
      check_estimate();
  end

  task automatic send_sample(input logic [TIME_W-1:0] t, input logic [PCT_W-1:0] p,
                             input logic chg, input logic plg, output bit produced);
    discharge_estimate_t est;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample_time <= t;
    in_charge_percent <= p;
    in_is_charging <= chg;
    in_is_plugged <= plg;
    @(posedge clk);
    while (!in_ready)
      @(posedge clk);
    produced = estimate_discharge(t, p, chg, plg, est);
    if (produced)
      estimates_due.push_back(est);
  endtask

  task automatic send_fixed(input logic [TIME_W-1:0] t, input int p, input logic chg,
                            input logic plg);
    bit produced;
    send_sample(t, p[PCT_W-1:0], chg, plg, produced);
    gen_time = t;
    gen_pct = p;
    gen_chg = chg;
    gen_plg = plg;
  endtask

  task automatic send_random_sample(output bit produced);
    int kind, p, drop;
    logic [TIME_W-1:0] t;
    logic chg, plg;
    kind = $urandom_range(0, 99);
    t = gen_time;
    p = gen_pct;
    chg = gen_chg;
    plg = gen_plg;
    if (kind < 55) begin
      // discharging step
      if ($urandom_range(0, 9) == 0)
        t = gen_time + TIME_W'($urandom_range(1, 1 << 24));
      else
        t = gen_time + TIME_W'($urandom_range(1, 20000));
      drop = $urandom_range(1, 4);
      p = (gen_pct >= drop) ? gen_pct - drop : $urandom_range(60, 100);
      chg = 1'b0;
      plg = ($urandom_range(0, 7) == 0);
    end else if (kind < 65) begin
      // repeated reading
      t = gen_time + TIME_W'($urandom_range(0, 5000));
    end else if (kind < 75) begin
      t = gen_time + TIME_W'($urandom_range(1, 20000));
      p = (gen_pct + 5 > 127) ? 127 : gen_pct + $urandom_range(1, 5);
      chg = 1'b1;
      plg = 1'b1;
    end else if (kind < 82) begin
      // time going backward or standing still
      t = gen_time - TIME_W'($urandom_range(0, 3000));
      p = (gen_pct > 0) ? gen_pct - 1 : 0;
      chg = 1'b0;
      plg = 1'b0;
    end else begin
      t = TIME_W'($urandom);
      p = $urandom_range(0, 127);
      chg = 1'($urandom_range(0, 1));
      plg = 1'($urandom_range(0, 1));
    end
    gen_time = t;
    gen_pct = p;
    gen_chg = chg;
    gen_plg = plg;
    send_sample(t, p[PCT_W-1:0], chg, plg, produced);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (estimates_due.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_default_rate(input logic signed [CFG_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_default_rate <= value;
    @(posedge clk);
    while (!cfg_ready)
      @(posedge clk);
    cfg_valid <= 1'b0;
    est_default_rate = longint'(value);
  endtask

  task automatic test_positive_default();
    write_default_rate(24'sh7FFFFF);
    // positive rate drives empty time below zero
    send_fixed(30'd0, 100, 1'b0, 1'b0);
  endtask

  task automatic test_field_extremes();
    send_fixed({TIME_W{1'b1}}, 127, 1'b1, 1'b1);
    send_fixed({TIME_W{1'b1}}, 127, 1'b1, 1'b1);
    send_fixed(30'd5, 0, 1'b0, 1'b0);
    send_fixed(30'd6, 0, 1'b0, 1'b1);
    send_fixed(30'd6, 0, 1'b0, 1'b1);
    send_fixed(30'd7, 0, 1'b1, 1'b1);
    send_fixed(30'd8, 0, 1'b1, 1'b0);
  endtask

  task automatic test_rate_update();
    send_fixed(30'd1000, 100, 1'b0, 1'b0);
    send_fixed(30'd4600, 99, 1'b0, 1'b0);
    send_fixed(30'd8200, 98, 1'b0, 1'b0);
    send_fixed(30'd20000, 95, 1'b0, 1'b1);
    send_fixed(30'h3FFFFC00, 0, 1'b0, 1'b0);
    // charging sample then a drop: verdict without update
    send_fixed(30'h3FFFFD00, 50, 1'b1, 1'b1);
    send_fixed(30'h3FFFFE00, 49, 1'b0, 1'b0);
    send_fixed(30'h3FFFFF00, 40, 1'b0, 1'b0);
    send_fixed(30'd100, 30, 1'b0, 1'b0);
    send_fixed(30'd90000, 29, 1'b0, 1'b0);
    send_fixed(30'd90000, 28, 1'b0, 1'b0);
    send_fixed(30'd180000, 1, 1'b0, 1'b0);
    send_fixed(30'd190000, 0, 1'b0, 1'b0);
  endtask

  task automatic test_backpressure();
    bit produced;
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    hold_trigger <= hold_trigger + 1;
    repeat (40) send_random_sample(produced);
  endtask

  task automatic test_random_phase(input int tx_idle, input int rx_stall, input int count,
                                   input logic signed [CFG_W-1:0] rate_setting);
    int results;
    bit produced;
    wait_idle();
    write_default_rate(rate_setting);
    tx_idle_pct = tx_idle;
    rx_stall_pct = rx_stall;
    results = 0;
    while (results < count) begin
      send_random_sample(produced);
      if (produced)
        results++;
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_positive_default();
    test_field_extremes();
    test_rate_update();
    wait_idle();
    test_backpressure();
    test_random_phase(0, 0, 380, -24'sd8388608);
    test_random_phase(51, 0, 380, 24'sd0);
    test_random_phase(0, 51, 380, -24'sd6048);
    test_random_phase(12, 12, 380, -$signed({1'b0, 23'($urandom)}));
    wait_idle();
    if (estimates_due.size() != 0)
      mismatches++;
    if (mismatches == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/dre_pkg.sv
rtl/dre_div.sv
rtl/dre_datapath.sv
rtl/dre_ctrl.sv
rtl/discharge_rate_estimator_core.sv
bench/testbench.sv
